### design/process_slot_pool_ready_queue_macros.svh
`ifndef PROCESS_SLOT_POOL_READY_QUEUE_MACROS_SVH
`define PROCESS_SLOT_POOL_READY_QUEUE_MACROS_SVH

// Checked only out of reset.
`define PSPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pspq_pkg.sv
package pspq_pkg;

	localparam int POOL_SIZE = 8;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int SLOT_W    = 4;
	localparam int SEG_W     = 16;
	localparam int OP_W      = 3;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SEG_W-1:0]  seg_t;

	localparam slot_t IDLE_SLOT = slot_t'(POOL_SIZE);
	localparam slot_t LINK_NONE = slot_t'(15);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_RELEASE  = 3'd1,
		OP_ENQUEUE  = 3'd2,
		OP_DEQUEUE  = 3'd3,
		OP_FIND     = 3'd4,
		OP_SET_SEG  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	// lowest set bit wins
	function automatic idx_t first_idx(input logic [POOL_SIZE-1:0] v);
		idx_t r;
		r = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (v[i]) r = idx_t'(i);
		end
		return r;
	endfunction

endpackage

### design/pspq_req_if.sv
interface pspq_req_if;
	import pspq_pkg::*;

	logic  valid;
	logic  ready;
	logic [OP_W-1:0] operation;
	slot_t slot;
	seg_t  segment;

	modport source (output valid, output operation, output slot, output segment, input ready);
	modport sink (input valid, input operation, input slot, input segment, output ready);
endinterface

### design/pspq_rsp_if.sv
interface pspq_rsp_if;
	import pspq_pkg::*;

	logic  valid;
	logic  ready;
	logic  found;
	slot_t result_slot;

	modport source (output valid, output found, output result_slot, input ready);
	modport sink (input valid, input found, input result_slot, output ready);
endinterface

### design/pspq_ctrl.sv
module pspq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pspq_pkg::dp_cmd_t cmd
);
	import pspq_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				out_valid = 1'b1;
				// next request may come in as this result leaves
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### design/pspq_dp.sv
`include "process_slot_pool_ready_queue_macros.svh"

module pspq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pspq_pkg::dp_cmd_t            cmd,
	input  logic [pspq_pkg::OP_W-1:0]    in_operation,
	input  pspq_pkg::slot_t              in_slot,
	input  pspq_pkg::seg_t               in_segment,
	output logic                         found,
	output pspq_pkg::slot_t              result_slot
);
	import pspq_pkg::*;

	// request registers
	op_t   op_q;
	slot_t slot_q;
	seg_t  seg_q;

	// slot tables and queue pointers
	logic [POOL_SIZE-1:0] busy_q;
	seg_t                 seg_mem_q [POOL_SIZE];
	slot_t                link_q [POOL_SIZE+1];
	slot_t                head_q;
	slot_t                tail_q;
	logic                 empty_q;

	logic                 found_q;
	slot_t                rslot_q;

	logic [POOL_SIZE-1:0] match;
	logic                 free_any, match_any;
	idx_t                 free_idx, match_idx, slot_idx;
	logic                 pool_slot, queue_slot;
	slot_t                head_link;
	logic                 deq_last;
	logic                 res_found;
	slot_t                res_slot;

	logic                 ptrs_clear;
	logic                 ptrs_in_range;
	logic                 alloc_go;
	int                   busy_cnt;

	assign slot_idx   = slot_q[IDX_W-1:0];
	assign pool_slot  = slot_q < IDLE_SLOT;
	assign queue_slot = slot_q <= IDLE_SLOT;

	always_comb begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			match[i] = seg_mem_q[i] == seg_q;
		end
	end

	assign free_any  = !(&busy_q);
	assign free_idx  = first_idx(~busy_q);
	assign match_any = |match;
	assign match_idx = first_idx(match);

	assign head_link = link_q[head_q];
	assign deq_last  = head_q == tail_q || head_q > IDLE_SLOT || head_link > IDLE_SLOT;

	always_comb begin
		res_found = 1'b0;
		res_slot  = '0;
		unique case (op_q)
			OP_ALLOC: begin
				res_found = free_any;
				res_slot  = slot_t'(free_idx);
			end
			OP_RELEASE, OP_ENQUEUE: begin
				res_found = queue_slot;
				res_slot  = slot_q;
			end
			OP_DEQUEUE: begin
				res_found = !empty_q;
				res_slot  = head_q;
			end
			OP_FIND: begin
				res_found = match_any;
				res_slot  = slot_t'(match_idx);
			end
			OP_SET_SEG: begin
				res_found = pool_slot;
				res_slot  = slot_q;
			end
			default: ;
		endcase
		if (!res_found) res_slot = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(in_operation);
			slot_q <= in_slot;
			seg_q  <= in_segment;
		end
		if (cmd.exec) begin
			found_q <= res_found;
			rslot_q <= res_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			for (int i = 0; i < POOL_SIZE; i++) begin
				seg_mem_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			case (op_q)
				OP_ALLOC: begin
					if (free_any) busy_q[free_idx] <= 1'b1;
				end
				OP_RELEASE: begin
					if (pool_slot) begin
						busy_q[slot_idx]    <= 1'b0;
						seg_mem_q[slot_idx] <= '0;
					end
				end
				OP_ENQUEUE: begin
					if (queue_slot) begin
						if (empty_q) begin
							head_q  <= slot_q;
							empty_q <= 1'b0;
						end
						tail_q <= slot_q;
					end
				end
				OP_DEQUEUE: begin
					if (!empty_q) begin
						if (deq_last) begin
							empty_q <= 1'b1;
							head_q  <= '0;
							tail_q  <= '0;
						end else begin
							head_q <= head_link;
						end
					end
				end
				OP_SET_SEG: begin
					if (pool_slot) seg_mem_q[slot_idx] <= seg_q;
				end
				default: ;
			endcase
		end
	end

	// links hold no reset value; the queue never follows one it has not written
	always_ff @(posedge clk) begin
		if (cmd.exec && queue_slot) begin
			if (op_q == OP_RELEASE) begin
				link_q[slot_q] <= LINK_NONE;
			end
			if (op_q == OP_ENQUEUE) begin
				// re-queueing the tail leaves it terminated
				if (!empty_q && tail_q != slot_q) link_q[tail_q] <= slot_q;
				link_q[slot_q] <= LINK_NONE;
			end
		end
	end

	assign found       = found_q;
	assign result_slot = rslot_q;

	assign ptrs_clear    = head_q == '0 && tail_q == '0;
	assign ptrs_in_range = head_q <= IDLE_SLOT && tail_q <= IDLE_SLOT;
	assign alloc_go      = cmd.exec && op_q == OP_ALLOC && free_any;
	assign busy_cnt      = $countones(busy_q);

	`PSPQ_ASSERT_ALWAYS(a_empty_ptrs, empty_q |-> ptrs_clear, "empty queue with stale pointers")
	`PSPQ_ASSERT(a_ptr_range, !empty_q |-> ptrs_in_range, "queue pointer beyond idle slot")
	`PSPQ_ASSERT(a_alloc_claims, alloc_go |=> busy_cnt == $past(busy_cnt) + 1, "alloc miscount")
endmodule

### design/process_slot_pool_ready_queue.sv
// Pool of eight process slots with a FIFO ready queue threaded through per-slot
// links; slot 8 is an extra idle slot that can be queued but has no busy bit or
// tag. Operations: alloc (lowest free slot), release, enqueue, dequeue, find by
// segment tag (lowest matching slot) and set segment. found is 0 on a full pool,
// empty queue, no match, out-of-range slot or unused code, and result_slot is
// then 0. A request is latched on acceptance, executed in the following cycle
// by a single read-modify-write of the slot tables, and its result is offered
// in the cycle after that. The next request is accepted in the cycle the result
// is taken, so a new request is not taken while one is still executing. The
// link table is not cleared at reset; each link is written by enqueue or
// release before the queue follows it.
module process_slot_pool_ready_queue (
	input logic      clk,
	input logic      arst_n,
	pspq_req_if.sink req,
	pspq_rsp_if.source rsp
);
	import pspq_pkg::*;

	dp_cmd_t cmd;

	pspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	pspq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_operation (req.operation),
		.in_slot      (req.slot),
		.in_segment   (req.segment),
		.found        (rsp.found),
		.result_slot  (rsp.result_slot)
	);
endmodule
